// ===== sv/text_pre_tokenizer_splitter_assert.svh =====
// ----------------------------------------------------------------------------
// Text pre-tokenizer assertion macros
// Concurrent assertion forms used by the splitter's back module (tpts_back).
// ----------------------------------------------------------------------------
`ifndef TEXT_PRE_TOKENIZER_SPLITTER_ASSERT_SVH
`define TEXT_PRE_TOKENIZER_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define TPTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tpts_pkg.sv =====
// ----------------------------------------------------------------------------
// Text pre-tokenizer package
// Byte classes, piece kinds, queue and result types, and the step decision
// used by the splitter sequencer.
// ----------------------------------------------------------------------------
package tpts_pkg;

    // Character constants.
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_Z  = "Z";
    localparam logic [7:0] CH_LO_A  = "a";
    localparam logic [7:0] CH_LO_Z  = "z";
    localparam logic [7:0] CH_D0    = "0";
    localparam logic [7:0] CH_D9    = "9";
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_S     = "s";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_M     = "m";
    localparam logic [7:0] CH_D     = "d";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_V     = "v";
    localparam logic [7:0] CH_L     = "l";
    localparam logic [7:0] CH_E     = "e";

    // Stream widths and lookahead depth.
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned BUF_DEPTH  = 4;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_LETTER,
        CLS_DIGIT,
        CLS_QUOTE,
        CLS_OTHER
    } t_cls;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LETTER,
        KIND_PUNCT
    } t_kind;

    typedef enum logic [1:0] {
        M_NONE,
        M_TWO,
        M_THREE,
        M_WAIT
    } t_match;

    typedef enum logic [1:0] {
        OP_STOP,
        OP_DROP,
        OP_EMIT
    } t_op;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq;

    // One classified, lowercased text byte.
    typedef struct packed {
        t_cls       cls;
        logic [7:0] data;
    } t_ent;

    typedef t_ent [BUF_DEPTH-1:0] t_buf;

    // Queue entry between the front and the back.
    typedef struct packed {
        logic last;
        t_ent ent;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic       te;
        logic       pe;
        logic       vld;
        logic [7:0] data;
    } t_result;

    // Decision of one sequencer step.
    typedef struct packed {
        t_op        op;
        logic       pe;
        t_kind      kind_nx;
        logic [1:0] cr_nx;
    } t_act;

    localparam t_ent    ENT_ZERO = '{cls: CLS_SPACE, data: 8'h00};
    localparam t_result RES_MARK = '{te: 1'b1, pe: 1'b0, vld: 1'b0, data: 8'h00};

    // Map A-Z to a-z, all other bytes unchanged.
    function automatic logic [7:0] tpts_lower(logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c | 8'h20;
        end
        return r;
    endfunction

    function automatic t_cls tpts_classify(logic [7:0] c);
        t_cls r;
        if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
            r = CLS_SPACE;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            r = CLS_LETTER;
        end else if (c >= CH_D0 && c <= CH_D9) begin
            r = CLS_DIGIT;
        end else if (c == CH_QUOTE) begin
            r = CLS_QUOTE;
        end else begin
            r = CLS_OTHER;
        end
        return r;
    endfunction

    // Contraction test for an apostrophe followed by b1 and b2.
    // Missing bytes wait for more input unless the text has ended.
    function automatic t_match tpts_match(logic [7:0] b1, logic [7:0] b2,
                                          logic has1, logic has2, logic fin);
        t_match r;
        if (!has1) begin
            r = fin ? M_NONE : M_WAIT;
        end else if (b1 == CH_S || b1 == CH_T || b1 == CH_M || b1 == CH_D) begin
            r = M_TWO;
        end else if (b1 != CH_R && b1 != CH_V && b1 != CH_L) begin
            r = M_NONE;
        end else if (!has2) begin
            r = fin ? M_NONE : M_WAIT;
        end else if (b1 == CH_L) begin
            r = (b2 == CH_L) ? M_THREE : M_NONE;
        end else begin
            r = (b2 == CH_E) ? M_THREE : M_NONE;
        end
        return r;
    endfunction

    // One step on the head of the lookahead buffer: drop a separator, emit
    // the head byte with its piece-end flag, or stop for more input.
    function automatic t_act tpts_eval(t_buf b, logic [2:0] n, t_kind kind,
                                       logic fin, logic [1:0] cr);
        t_act   a;
        t_kind  ek;
        t_match m;
        logic   fixed;
        logic   pend;
        logic   wait_more;
        a.op      = OP_STOP;
        a.pe      = 1'b0;
        a.kind_nx = kind;
        a.cr_nx   = 2'd0;
        ek        = kind;
        fixed     = 1'b0;
        pend      = 1'b0;
        wait_more = 1'b0;
        m         = M_NONE;

        if (cr != 2'd0) begin
            // Remaining bytes of a contraction.
            a.op      = OP_EMIT;
            a.pe      = (cr == 2'd1);
            a.kind_nx = KIND_NONE;
            a.cr_nx   = cr - 2'd1;
            fixed     = 1'b1;
        end else if (n == 3'd0) begin
            fixed = 1'b1;
        end else if (kind == KIND_NONE) begin
            // Start of a new piece.
            unique case (b[0].cls)
                CLS_SPACE: begin
                    a.op  = OP_DROP;
                    fixed = 1'b1;
                end
                CLS_QUOTE: begin
                    m = tpts_match(b[1].data, b[2].data, n >= 3'd2, n >= 3'd3, fin);
                    unique case (m)
                        M_WAIT: fixed = 1'b1;
                        M_TWO: begin
                            a.op      = OP_EMIT;
                            a.kind_nx = KIND_NONE;
                            a.cr_nx   = 2'd1;
                            fixed     = 1'b1;
                        end
                        M_THREE: begin
                            a.op      = OP_EMIT;
                            a.kind_nx = KIND_NONE;
                            a.cr_nx   = 2'd2;
                            fixed     = 1'b1;
                        end
                        M_NONE: ek = KIND_PUNCT;
                    endcase
                end
                CLS_LETTER: ek = KIND_LETTER;
                CLS_DIGIT: begin
                    a.op      = OP_EMIT;
                    a.pe      = 1'b1;
                    a.kind_nx = KIND_NONE;
                    fixed     = 1'b1;
                end
                default: ek = KIND_PUNCT;
            endcase
        end

        // Open letter or punctuation run: decide from the next byte.
        if (!fixed) begin
            a.kind_nx = ek;
            if (n < 3'd2) begin
                wait_more = !fin;
                pend      = 1'b1;
            end else if (ek == KIND_LETTER) begin
                pend = (b[1].cls != CLS_LETTER);
            end else begin
                unique case (b[1].cls)
                    CLS_SPACE, CLS_LETTER, CLS_DIGIT: pend = 1'b1;
                    CLS_QUOTE: begin
                        m = tpts_match(b[2].data, b[3].data, n >= 3'd3, n >= 3'd4, fin);
                        wait_more = (m == M_WAIT);
                        pend      = (m == M_TWO) || (m == M_THREE);
                    end
                    default: pend = 1'b0;
                endcase
            end
            if (!wait_more) begin
                a.op      = OP_EMIT;
                a.pe      = pend;
                a.kind_nx = pend ? KIND_NONE : ek;
            end
        end
        return a;
    endfunction

endpackage

// ===== sv/tpts_front.sv =====
// ----------------------------------------------------------------------------
// Text pre-tokenizer front
// Accepts input beats, lowercases and classifies each byte, and queues it
// in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module tpts_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tvalid,
    output logic                            o_tready,
    input  logic [tpts_pkg::IN_DATA_W-1:0]  i_tdata,    // [7:0] in_byte
    input  logic                            i_tlast,
    output logic                            o_q_valid,
    input  logic                            i_q_ready,
    output tpts_pkg::t_item                 o_q_item
);
    import tpts_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;
    t_item      w_item;
    logic [7:0] w_low;

    // Lowercase and classify the incoming byte.
    always_comb begin
        w_low           = tpts_lower(i_tdata[7:0]);
        w_item.last     = i_tlast;
        w_item.ent.data = w_low;
        w_item.ent.cls  = tpts_classify(w_low);
    end

    // Queue pointers and fill count.
    always_comb begin
        o_tready  = (r_cnt != 2'd2);
        o_q_valid = (r_cnt != 2'd0);
        o_q_item  = r_q[r_rp];
        w_push    = i_tvalid && o_tready;
        w_pop     = o_q_valid && i_q_ready;
        n_wp      = w_push ? !r_wp : r_wp;
        n_rp      = w_pop ? !r_rp : r_rp;
        n_cnt     = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

// ===== sv/tpts_back.sv =====
// ----------------------------------------------------------------------------
// Text pre-tokenizer back
// Lookahead buffer and piece sequencer: one drop or emit step per cycle
// unless the output register that results leave through is full. The next
// step is checked ahead, so a finished byte frees the sequencer that cycle.
// ----------------------------------------------------------------------------
`include "text_pre_tokenizer_splitter_assert.svh"

module tpts_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  tpts_pkg::t_item                 i_q_item,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [tpts_pkg::OUT_DATA_W-1:0] o_tdata,    // [7:0] out_byte, [8] piece_end
    output logic [0:0]                      o_tuser,    // [0] byte_valid
    output logic                            o_tlast
);
    import tpts_pkg::*;

    t_seq       r_state, n_state;
    t_buf       r_buf, n_buf;
    logic [2:0] r_cnt, n_cnt;
    t_kind      r_kind, n_kind;
    logic [1:0] r_cr, n_cr;
    logic       r_fin, n_fin;
    t_result    r_hold, n_hold;
    logic       r_hold_v, n_hold_v;
    t_result    r_out, n_out;
    logic       r_out_v, n_out_v;

    t_act       w_act;
    t_act       w_act2;
    t_buf       w_buf1;
    logic [2:0] w_cnt1;
    logic       w_run;
    logic       w_emit;
    logic       w_stop_now;
    logic       w_stop_after;
    logic       w_done;
    logic       w_out_wr;
    logic       w_out_free;
    logic       w_adv;
    logic       w_step;
    logic       w_load;
    t_result    w_res;
    t_result    w_fin_res;
    t_buf       w_post_buf;
    logic [2:0] w_post_cnt;
    t_kind      w_post_kind;
    logic [1:0] w_post_cr;

    // Current step and a look at the step after it.
    always_comb begin
        w_act  = tpts_eval(r_buf, r_cnt, r_kind, r_fin, r_cr);
        w_buf1 = {ENT_ZERO, r_buf[BUF_DEPTH-1:1]};
        w_cnt1 = r_cnt - 3'd1;
        w_act2 = tpts_eval(w_buf1, w_cnt1, w_act.kind_nx, r_fin, w_act.cr_nx);
    end

    // Step control: when the sequencer may move and when an item is done.
    always_comb begin
        w_run        = (r_state == SEQ_RUN);
        w_emit       = w_run && (w_act.op == OP_EMIT);
        w_stop_now   = w_run && (w_act.op == OP_STOP);
        w_stop_after = w_run && !r_fin && (w_act.op != OP_STOP) && (w_act2.op == OP_STOP);
        w_done       = w_stop_now || w_stop_after;
        w_out_wr     = (w_emit && (!r_fin || r_hold_v)) || (w_stop_now && r_fin);
        w_out_free   = !r_out_v || i_tready;
        w_adv        = w_run && (!w_out_wr || w_out_free);
        w_step       = !w_run || w_adv;
        o_q_ready    = !w_run || (w_adv && w_done);
        w_load       = o_q_ready && i_q_valid;

        w_res.te   = 1'b0;
        w_res.pe   = w_act.pe;
        w_res.vld  = 1'b1;
        w_res.data = r_buf[0].data;
        w_fin_res    = r_hold;
        w_fin_res.te = 1'b1;
    end

    // Lookahead state after this cycle's step.
    always_comb begin
        if (!w_run) begin
            w_post_buf  = r_buf;
            w_post_cnt  = r_cnt;
            w_post_kind = r_kind;
            w_post_cr   = r_cr;
        end else if (w_stop_now) begin
            w_post_buf  = r_buf;
            w_post_cnt  = r_cnt;
            w_post_kind = w_act.kind_nx;
            w_post_cr   = 2'd0;
        end else begin
            w_post_buf  = w_buf1;
            w_post_cnt  = w_cnt1;
            w_post_kind = w_stop_after ? w_act2.kind_nx : w_act.kind_nx;
            w_post_cr   = w_act.cr_nx;
        end
        // The end of the text returns the lookahead to its reset state.
        if (w_done && r_fin) begin
            w_post_cnt  = 3'd0;
            w_post_kind = KIND_NONE;
            w_post_cr   = 2'd0;
        end
    end

    // Next state, lookahead update and item load.
    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        n_cr    = r_cr;
        n_fin   = r_fin;
        if (w_step) begin
            n_buf  = w_post_buf;
            n_cnt  = w_post_cnt;
            n_kind = w_post_kind;
            n_cr   = w_post_cr;
        end
        unique case (r_state)
            SEQ_IDLE: begin
                if (w_load) begin
                    n_state = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (w_adv && w_done && !w_load) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
        if (w_load) begin
            n_buf[w_post_cnt[1:0]] = i_q_item.ent;
            n_cnt                  = w_post_cnt + 3'd1;
            n_fin                  = i_q_item.last;
        end
    end

    // Result path. During the final item the newest result waits in the
    // hold register until it is known whether it is the last one.
    always_comb begin
        n_out    = r_out;
        n_out_v  = r_out_v && !i_tready;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        if (w_adv) begin
            if (w_emit) begin
                if (!r_fin) begin
                    n_out   = w_res;
                    n_out_v = 1'b1;
                end else begin
                    if (r_hold_v) begin
                        n_out   = r_hold;
                        n_out_v = 1'b1;
                    end
                    n_hold   = w_res;
                    n_hold_v = 1'b1;
                end
            end else if (w_stop_now && r_fin) begin
                n_out    = r_hold_v ? w_fin_res : RES_MARK;
                n_out_v  = 1'b1;
                n_hold_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SEQ_IDLE;
            r_cnt    <= 3'd0;
            r_kind   <= KIND_NONE;
            r_cr     <= 2'd0;
            r_fin    <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_kind   <= n_kind;
            r_cr     <= n_cr;
            r_fin    <= n_fin;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_buf  <= n_buf;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    // Output beat.
    always_comb begin
        o_tvalid   = r_out_v;
        o_tdata    = {{(OUT_DATA_W - 9){1'b0}}, r_out.pe, r_out.data};
        o_tuser[0] = r_out.vld;
        o_tlast    = r_out.te;
    end

    `TPTS_ASSERT_IMPLY(a_idle_pending, i_clk, i_rst_n, r_state == SEQ_IDLE, (r_cnt <= 3'd3) && (r_cr == 2'd0), "idle sequencer holds more than three bytes or a contraction")
    `TPTS_ASSERT_IMPLY(a_cr_bytes, i_clk, i_rst_n, r_cr != 2'd0, r_cnt >= 3'(r_cr), "contraction bytes missing from lookahead")
    `TPTS_ASSERT_IMPLY(a_marker_end, i_clk, i_rst_n, r_out_v && !r_out.vld, r_out.te, "bare marker beat without text end")
    `TPTS_ASSERT_IMPLY(a_hold_fin, i_clk, i_rst_n, r_hold_v, r_fin && (r_state == SEQ_RUN), "held result outside the final item")
    `TPTS_ASSERT_NEXT(a_fin_clears, i_clk, i_rst_n, w_adv && w_done && r_fin, !r_hold_v && (r_kind == KIND_NONE || w_load), "text end left a held result or open piece")

endmodule

// ===== sv/text_pre_tokenizer_splitter.sv =====
// ----------------------------------------------------------------------------
// Text pre-tokenizer splitter
// Path: a result beat passes through the input queue, the lookahead buffer and the output
// register; the last result of a text also waits in the hold register for the text-end mark.
// Throughput: one input beat per cycle while the sequencer and output keep up; each result or
// dropped separator past the first takes its own sequencer step, and a final byte adds a stop step.
// Reset: synchronous, active low; clears the queue, lookahead count and open piece.
// ----------------------------------------------------------------------------
module text_pre_tokenizer_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] piece_end, [15:9] zero
    output logic [0:0]  m_axis_tuser,   // [0] byte_valid
    output logic        m_axis_tlast    // text_end
);
    import tpts_pkg::*;

    logic  w_q_valid;
    logic  w_q_ready;
    t_item w_q_item;

    // Byte intake, classification and queue.
    tpts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_tlast   (s_axis_tlast),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_item  (w_q_item)
    );

    // Lookahead, piece sequencing and result output.
    tpts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_item  (w_q_item),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

endmodule

// ===== verif/text_pre_tokenizer_splitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text pre-tokenizer splitter testbench
// Streams short texts into the splitter and checks every result beat against
// a piece splitter kept in the bench. The texts are a few hand-picked ones
// first, then random ones built mostly from words, contractions, digits,
// punctuation and whitespace, with some noise bytes and broken contractions.
// Both stream sides idle at random in changing proportions.
// ----------------------------------------------------------------------------
module text_pre_tokenizer_splitter_tb;
    import tpts_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_BYTES   = 420;
    localparam int NEED_MORE      = -1;

    typedef struct packed {
        logic       last;
        logic [7:0] ch;
    } t_text_beat;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] out_byte, [8] piece_end, [15:9] zero
    logic [0:0]  m_axis_tuser;           // [0] byte_valid
    logic        m_axis_tlast;           // text_end

    t_text_beat text_bytes[$];
    t_result    expected_beats[$];
    t_text_beat next_beat;
    t_result    want_beat;
    int         total_bytes    = 1;
    int         accepted_bytes = 0;
    int         error_count    = 0;
    int         quiet_cycles   = 0;

    // Splitter state kept by the bench: bytes held back and the open piece.
    logic [7:0] held[0:3];
    int         held_cnt   = 0;
    t_kind      run_kind   = KIND_NONE;
    int         step_beats = 0;

    string contractions[7] = '{"'re", "'ve", "'ll", "'s", "'t", "'m", "'d"};

    text_pre_tokenizer_splitter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c >= CH_LO_A && c <= CH_LO_Z;
    endfunction

    function automatic logic is_numeral(logic [7:0] c);
        return c >= CH_D0 && c <= CH_D9;
    endfunction

    // Length of a contraction starting at held[p]; NEED_MORE while undecided.
    function automatic int contraction_len(int p, logic fin);
        logic [7:0] c1;
        if (p >= held_cnt || held[p] != CH_QUOTE) begin
            return 0;
        end
        if (p + 1 >= held_cnt) begin
            return fin ? 0 : NEED_MORE;
        end
        c1 = held[p + 1];
        if (c1 == CH_S || c1 == CH_T || c1 == CH_M || c1 == CH_D) begin
            return 2;
        end
        if (c1 != CH_R && c1 != CH_V && c1 != CH_L) begin
            return 0;
        end
        if (p + 2 >= held_cnt) begin
            return fin ? 0 : NEED_MORE;
        end
        if (c1 == CH_L) begin
            return (held[p + 2] == CH_L) ? 3 : 0;
        end
        return (held[p + 2] == CH_E) ? 3 : 0;
    endfunction

    function automatic void drop_head(int k);
        for (int i = 0; i + k < 4; i++) begin
            held[i] = held[i + k];
        end
        held_cnt -= k;
    endfunction

    function automatic void push_beat(logic [7:0] data, logic vld, logic pe);
        t_result r;
        r.te   = 1'b0;
        r.pe   = pe;
        r.vld  = vld;
        r.data = data;
        expected_beats.insert(expected_beats.size(), r);
        step_beats++;
    endfunction

    // Appends one text byte to the pending stimulus.
    function automatic void add_beat(logic [7:0] ch, logic last);
        t_text_beat tb_beat;
        tb_beat.ch   = ch;
        tb_beat.last = last;
        text_bytes.insert(text_bytes.size(), tb_beat);
    endfunction

    // Takes one text byte and queues the result beats it releases.
    function automatic void split_text_byte(logic [7:0] raw, logic fin);
        logic [7:0] b;
        logic [7:0] d;
        logic       stall;
        logic       decided;
        logic       ends;
        int         m;
        stall      = 1'b0;
        step_beats = 0;
        held[held_cnt] = (raw >= CH_UP_A && raw <= CH_UP_Z) ? raw + 8'd32 : raw;
        held_cnt++;

        while (held_cnt > 0 && !stall) begin
            b = held[0];
            if (run_kind == KIND_NONE) begin
                // Piece start: separator, contraction, letter, digit or punctuation.
                if (is_blank(b)) begin
                    drop_head(1);
                end else if (b == CH_QUOTE) begin
                    m = contraction_len(0, fin);
                    if (m == NEED_MORE) begin
                        stall = 1'b1;
                    end else if (m > 0) begin
                        for (int i = 0; i < m; i++) begin
                            push_beat(held[i], 1'b1, i == m - 1);
                        end
                        drop_head(m);
                    end else begin
                        run_kind = KIND_PUNCT;
                    end
                end else if (is_alpha(b)) begin
                    run_kind = KIND_LETTER;
                end else if (is_numeral(b)) begin
                    push_beat(b, 1'b1, 1'b1);
                    drop_head(1);
                end else begin
                    run_kind = KIND_PUNCT;
                end
            end else begin
                // Open run: the following byte decides whether the head ends it.
                decided = 1'b1;
                ends    = 1'b0;
                if (held_cnt < 2) begin
                    if (!fin) begin
                        stall   = 1'b1;
                        decided = 1'b0;
                    end else begin
                        ends = 1'b1;
                    end
                end else if (run_kind == KIND_LETTER) begin
                    ends = !is_alpha(held[1]);
                end else begin
                    d = held[1];
                    if (is_blank(d) || is_alpha(d) || is_numeral(d)) begin
                        ends = 1'b1;
                    end else if (d == CH_QUOTE) begin
                        m = contraction_len(1, fin);
                        if (m == NEED_MORE) begin
                            stall   = 1'b1;
                            decided = 1'b0;
                        end else begin
                            ends = m > 0;
                        end
                    end
                end
                if (decided) begin
                    push_beat(b, 1'b1, ends);
                    drop_head(1);
                    if (ends) begin
                        run_kind = KIND_NONE;
                    end
                end
            end
        end

        // The final byte flushes everything and marks the text end.
        if (fin) begin
            if (step_beats == 0) begin
                push_beat(8'h00, 1'b0, 1'b0);
            end
            expected_beats[expected_beats.size() - 1].te = 1'b1;
            held_cnt = 0;
            run_kind = KIND_NONE;
        end else if (held_cnt > 3) begin
            held_cnt = 3;
        end
    endfunction

    // Idle share in percent for the current third of the run.
    function automatic int idle_pct(logic for_rx);
        case (accepted_bytes * 3 / total_bytes)
            0:       return for_rx ? 86 : 36;
            1:       return for_rx ? 36 : 86;
            default: return 0;
        endcase
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            add_beat(s[i], i == s.len() - 1);
        end
    endtask

    // Sender: offers the next byte once the current beat is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                split_text_byte(s_axis_tdata, s_axis_tlast);
                accepted_bytes++;
            end
            if (text_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                next_beat = text_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_beat.ch;
                s_axis_tlast  <= next_beat.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure and a check of every result beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got %h/%b/%b/%b",
                             $time, m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[8],
                             m_axis_tlast);
                    error_count++;
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (m_axis_tdata[7:0] !== want_beat.data ||
                        m_axis_tuser[0] !== want_beat.vld ||
                        m_axis_tdata[8] !== want_beat.pe ||
                        m_axis_tlast !== want_beat.te) begin
                        $display("%0t: mismatch, expected %h/%b/%b/%b, got %h/%b/%b/%b",
                                 $time, want_beat.data, want_beat.vld, want_beat.pe,
                                 want_beat.te, m_axis_tdata[7:0], m_axis_tuser[0],
                                 m_axis_tdata[8], m_axis_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (i_rst_n && quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else if (i_rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] txt[$];
        logic [7:0] c;
        string      s;
        string      punct;
        int         random_bytes;
        punct        = ",.!?-;\"'()#";
        random_bytes = 0;

        // Hand-picked texts: contractions other than 's and 'd, runs cut by contractions,
        // a lone separator, extreme bytes, and incomplete contractions at the end.
        add_text("Z're'LL!'t'm");
        add_text(" ");
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(CH_QUOTE, 1'b0);
        add_beat(CH_R, 1'b1);
        add_text("9d'Ve\t'");

        // Random texts, mostly built from well-formed pieces.
        while (random_bytes < RANDOM_BYTES) begin
            txt.delete();
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        repeat ($urandom_range(1, 5)) begin
                            c = 8'($urandom_range(0, 25));
                            txt.insert(txt.size(),
                                       c + ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A));
                        end
                    end
                    3, 4: begin
                        s = contractions[$urandom_range(0, 6)];
                        for (int i = 0; i < s.len(); i++) begin
                            c = s[i];
                            if (c != CH_QUOTE && $urandom_range(0, 3) == 0) begin
                                c = c - 8'd32;
                            end
                            txt.insert(txt.size(), c);
                        end
                    end
                    5: begin
                        repeat ($urandom_range(1, 3)) begin
                            txt.insert(txt.size(), CH_D0 + 8'($urandom_range(0, 9)));
                        end
                    end
                    6: begin
                        repeat ($urandom_range(1, 3)) begin
                            if ($urandom_range(0, 2) == 0) begin
                                txt.insert(txt.size(), 8'($urandom_range(128, 255)));
                            end else begin
                                c = punct[$urandom_range(0, punct.len() - 1)];
                                txt.insert(txt.size(), c);
                            end
                        end
                    end
                    7: begin
                        repeat ($urandom_range(1, 2)) begin
                            c = 8'($urandom_range(8, 13));
                            txt.insert(txt.size(), (c == 8'd8) ? CH_SP : c);
                        end
                    end
                    8: begin
                        txt.insert(txt.size(), 8'($urandom_range(0, 255)));
                    end
                    default: begin
                        // Apostrophe that may or may not start a contraction.
                        s = "rvlx";
                        txt.insert(txt.size(), CH_QUOTE);
                        c = s[$urandom_range(0, 3)];
                        txt.insert(txt.size(), c);
                        if ($urandom_range(0, 1)) begin
                            txt.insert(txt.size(), CH_LO_A + 8'($urandom_range(0, 25)));
                        end
                    end
                endcase
            end
            foreach (txt[i]) begin
                add_beat(txt[i], i == txt.size() - 1);
            end
            random_bytes += txt.size();
        end
        total_bytes = text_bytes.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_bytes.size() > 0 || s_axis_tvalid || expected_beats.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tpts_pkg.sv
sv/tpts_front.sv
sv/tpts_back.sv
sv/text_pre_tokenizer_splitter.sv
verif/text_pre_tokenizer_splitter_tb.sv
